FILE: design/tlptm_pkg.sv
// shared types and codes for the two-level page table manager
package tlptm_pkg;

  localparam int PAGE_W  = 21;
  localparam int FRAME_W = 20;

  localparam logic [1:0] CMD_TRANSLATE = 2'd0;
  localparam logic [1:0] CMD_MAP       = 2'd1;
  localparam logic [1:0] CMD_UNMAP     = 2'd2;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_MAPPED   = 3'd1;
  localparam logic [2:0] ST_UNMAPPED = 3'd2;
  localparam logic [2:0] ST_ALIGN    = 3'd3;
  localparam logic [2:0] ST_RANGE    = 3'd4;

  localparam logic [1:0]         DIR_FLAGS   = 2'b11;
  localparam logic [FRAME_W-1:0] FRAME_RESET = 20'd256;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [23:0] virt_addr;
    logic [31:0] phys_addr;
    logic [11:0] page_flags;
    logic [12:0] page_count;
  } in_beat_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] trans_addr;
    logic [12:0] pages_done;
  } out_beat_t;

  typedef enum logic [2:0] {
    S_IDLE, S_DISPATCH, S_WALK, S_CLEAR, S_CHECK, S_TRANS, S_OUT
  } state_t;

  typedef struct packed {
    logic       load;
    logic       start_clear;
    logic       clr_step;
    logic       rd_en;
    logic       wr_map;
    logic       wr_unmap;
    logic       inc;
    logic       res_en;
    logic [2:0] res_status;
    logic       res_trans;
  } dp_cmd_t;

  typedef struct packed {
    logic [1:0] cmd;
    logic       misaligned;
    logic       done_eq;
    logic       oob;
    logic       dir_present;
    logic       entry_present;
    logic       clr_last;
  } dp_stat_t;

endpackage

FILE: design/tlptm_dp.sv
// datapath: directory, table memory, walk counters and result register
module tlptm_dp #(
  parameter int DIR_BITS   = 4,
  parameter int TABLE_BITS = 8
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  tlptm_pkg::in_beat_t           in_data,
  input  logic                          cfg_valid,
  input  logic [tlptm_pkg::FRAME_W-1:0] cfg_data,
  input  tlptm_pkg::dp_cmd_t            cmd,
  output tlptm_pkg::dp_stat_t           stat,
  output tlptm_pkg::out_beat_t          out_data
);
  import tlptm_pkg::*;

  localparam int AW        = DIR_BITS + TABLE_BITS;
  localparam int DIR_DEPTH = 1 << DIR_BITS;
  localparam int TBL_DEPTH = 1 << AW;

  logic [22:0]         dir_r [DIR_DEPTH];
  logic [31:0]         table_mem [TBL_DEPTH];
  logic [31:0]         rdata_r;
  logic [FRAME_W-1:0]  next_frame_r;
  in_beat_t            item_r;
  logic [PAGE_W-1:0]   page_r;
  logic [12:0]         done_r;
  logic [31:0]         pa_r;
  logic [TABLE_BITS-1:0] clr_r;
  out_beat_t           res_r;

  logic [DIR_BITS-1:0] dir_idx;
  logic                we;
  logic [AW-1:0]       waddr;
  logic [31:0]         wdata;

  assign dir_idx = page_r[AW-1:TABLE_BITS];

  always_comb begin
    we    = cmd.clr_step | cmd.wr_map | cmd.wr_unmap;
    waddr = page_r[AW-1:0];
    wdata = '0;
    if (cmd.clr_step) begin
      waddr = {dir_idx, clr_r};
    end else if (cmd.wr_map) begin
      wdata = pa_r | {20'd0, item_r.page_flags} | 32'd1;
    end else if (cmd.wr_unmap) begin
      wdata = {rdata_r[31:1], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      table_mem[waddr] <= wdata;
    end
    if (cmd.rd_en) begin
      rdata_r <= table_mem[page_r[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < DIR_DEPTH; i++) dir_r[i] <= '0;
      next_frame_r <= FRAME_RESET;
    end else begin
      if (cfg_valid) begin
        next_frame_r <= cfg_data;
      end else if (cmd.start_clear) begin
        dir_r[dir_idx] <= {next_frame_r, 1'b0, DIR_FLAGS};
        next_frame_r   <= next_frame_r + FRAME_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item_r <= in_data;
      page_r <= PAGE_W'(in_data.virt_addr[23:12]);
      done_r <= '0;
      pa_r   <= in_data.phys_addr;
    end else if (cmd.inc) begin
      page_r <= page_r + PAGE_W'(1);
      done_r <= done_r + 13'd1;
      pa_r   <= pa_r + 32'h1000;
    end
    if (cmd.start_clear) begin
      clr_r <= '0;
    end else if (cmd.clr_step) begin
      clr_r <= clr_r + TABLE_BITS'(1);
    end
    if (cmd.res_en) begin
      res_r.status     <= cmd.res_status;
      res_r.trans_addr <= cmd.res_trans ? {rdata_r[31:12], item_r.virt_addr[11:0]} : 32'd0;
      res_r.pages_done <= done_r;
    end
  end

  always_comb begin
    stat.cmd           = item_r.cmd;
    stat.misaligned    = (item_r.virt_addr[11:0] != 12'd0) ||
                         ((item_r.cmd == CMD_MAP) && (item_r.phys_addr[11:0] != 12'd0));
    stat.done_eq       = (done_r == item_r.page_count);
    stat.oob           = (page_r >> AW) != '0;
    stat.dir_present   = dir_r[dir_idx][0];
    stat.entry_present = rdata_r[0];
    stat.clr_last      = &clr_r;
  end

  assign out_data = res_r;

endmodule

FILE: design/tlptm_ctrl.sv
// controller: command sequencing, page walk and table clearing
module tlptm_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  output logic                 out_valid,
  input  logic                 out_stall,
  input  tlptm_pkg::dp_stat_t  stat,
  output tlptm_pkg::dp_cmd_t   cmd
);
  import tlptm_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_stall  = (state_r != S_IDLE);
    out_valid = (state_r == S_OUT);
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        case (stat.cmd)
          CMD_TRANSLATE: begin
            if (stat.oob) begin
              cmd.res_en = 1'b1; cmd.res_status = ST_RANGE; state_nxt = S_OUT;
            end else if (!stat.dir_present) begin
              cmd.res_en = 1'b1; cmd.res_status = ST_UNMAPPED; state_nxt = S_OUT;
            end else begin
              cmd.rd_en = 1'b1; state_nxt = S_TRANS;
            end
          end
          CMD_MAP, CMD_UNMAP: begin
            if (stat.misaligned) begin
              cmd.res_en = 1'b1; cmd.res_status = ST_ALIGN; state_nxt = S_OUT;
            end else begin
              state_nxt = S_WALK;
            end
          end
          default: begin
            cmd.res_en = 1'b1; cmd.res_status = ST_OK; state_nxt = S_OUT;
          end
        endcase
      end
      S_WALK: begin
        if (stat.done_eq) begin
          cmd.res_en = 1'b1; cmd.res_status = ST_OK; state_nxt = S_OUT;
        end else if (stat.oob) begin
          cmd.res_en = 1'b1; cmd.res_status = ST_RANGE; state_nxt = S_OUT;
        end else if (!stat.dir_present && stat.cmd == CMD_MAP) begin
          cmd.start_clear = 1'b1; state_nxt = S_CLEAR;
        end else if (!stat.dir_present) begin
          cmd.res_en = 1'b1; cmd.res_status = ST_UNMAPPED; state_nxt = S_OUT;
        end else begin
          cmd.rd_en = 1'b1; state_nxt = S_CHECK;
        end
      end
      S_CLEAR: begin
        // zero the new table one entry a cycle
        cmd.clr_step = 1'b1;
        if (stat.clr_last) state_nxt = S_WALK;
      end
      S_CHECK: begin
        if (stat.cmd == CMD_MAP) begin
          if (stat.entry_present) begin
            cmd.res_en = 1'b1; cmd.res_status = ST_MAPPED; state_nxt = S_OUT;
          end else begin
            cmd.wr_map = 1'b1; cmd.inc = 1'b1; state_nxt = S_WALK;
          end
        end else begin
          if (!stat.entry_present) begin
            cmd.res_en = 1'b1; cmd.res_status = ST_UNMAPPED; state_nxt = S_OUT;
          end else begin
            cmd.wr_unmap = 1'b1; cmd.inc = 1'b1; state_nxt = S_WALK;
          end
        end
      end
      S_TRANS: begin
        cmd.res_en = 1'b1;
        if (stat.entry_present) begin
          cmd.res_status = ST_OK; cmd.res_trans = 1'b1;
        end else begin
          cmd.res_status = ST_UNMAPPED;
        end
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (!out_stall) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  a_no_write_past_count: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.wr_map || cmd.wr_unmap) |-> (!stat.done_eq && !stat.oob))
    else $error("table write beyond the run");
  a_clear_only_on_map: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.start_clear |-> (stat.cmd == CMD_MAP && !stat.dir_present))
    else $error("table clear without a missing directory entry on map");
  a_result_then_out: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.res_en |=> out_valid)
    else $error("result captured but not presented");
  a_busy_while_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall)
    else $error("input taken while result pending");

endmodule

FILE: design/two_level_page_table_manager_top.sv
// top level of the two-level page table manager
//  channel | direction | handshake         | beat
//  in_     | input     | in_valid/in_stall | in_beat_t command
//  out_    | output    | out_valid/out_stall | out_beat_t result
//  cfg_    | input     | cfg_valid/cfg_ready | table frame base
// one command at a time; translate passes IDLE, DISPATCH, TRANS and OUT, skipping TRANS
// when the directory entry is absent
// map/unmap pass WALK and CHECK for each page in the single table memory,
// plus a CLEAR of all 2^TABLE_BITS entries per new directory entry (table clear)
// synchronous active-low reset clears the directory; table memory is not cleared
// in_stall is high from acceptance until the result beat is taken
module two_level_page_table_manager_top #(
  parameter int DIR_BITS   = 4,
  parameter int TABLE_BITS = 8
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  tlptm_pkg::in_beat_t           in_data,
  output logic                          out_valid,
  input  logic                          out_stall,
  output tlptm_pkg::out_beat_t          out_data,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [tlptm_pkg::FRAME_W-1:0] cfg_data
);
  import tlptm_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  assign cfg_ready = 1'b1;

  tlptm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  tlptm_dp #(
    .DIR_BITS   (DIR_BITS),
    .TABLE_BITS (TABLE_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_valid (cfg_valid & cfg_ready),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .stat      (stat),
    .out_data  (out_data)
  );

endmodule

FILE: test/page_table_checker.sv
// checker for the two-level page table manager: predicts results and compares beats
module page_table_checker #(
  parameter int DIR_BITS   = 4,
  parameter int TABLE_BITS = 8
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_stall,
  input  tlptm_pkg::in_beat_t  in_data,
  input  logic                 out_valid,
  input  logic                 out_stall,
  input  tlptm_pkg::out_beat_t out_data,
  input  logic                 cfg_valid,
  input  logic                 cfg_ready,
  input  logic [tlptm_pkg::FRAME_W-1:0] cfg_data,
  output int                   fail_count,
  output int                   pending,
  output int                   results_seen
);
  timeunit 1ns;
  timeprecision 1ps;
  import tlptm_pkg::*;

  localparam int DIR_DEPTH = 1 << DIR_BITS;
  localparam int TBL_DEPTH = 1 << TABLE_BITS;
  localparam int ALL_PAGES = 1 << (DIR_BITS + TABLE_BITS);

  logic [22:0]        dir_shadow [DIR_DEPTH];
  logic [31:0]        pte_shadow [ALL_PAGES];
  logic [FRAME_W-1:0] frame_next;
  out_beat_t          expected_q [$];

  function automatic out_beat_t walk_tables(in_beat_t c);
    out_beat_t r;
    int unsigned vpn, pg, d;
    logic [31:0] e;
    r = '0;
    vpn = c.virt_addr >> 12;
    if (c.cmd == CMD_TRANSLATE) begin
      if (vpn >= ALL_PAGES) begin
        r.status = ST_RANGE;
      end else begin
        d = vpn >> TABLE_BITS;
        e = pte_shadow[vpn];
        if (!dir_shadow[d][0] || !e[0]) r.status = ST_UNMAPPED;
        else r.trans_addr = {e[31:12], 12'h000} + c.virt_addr[11:0];
      end
    end else if (c.cmd == CMD_MAP || c.cmd == CMD_UNMAP) begin
      if (c.virt_addr[11:0] != 0 || (c.cmd == CMD_MAP && c.phys_addr[11:0] != 0)) begin
        r.status = ST_ALIGN;
      end else begin
        while (r.pages_done < c.page_count) begin
          pg = vpn + r.pages_done;
          if (pg >= ALL_PAGES) begin
            r.status = ST_RANGE;
            break;
          end
          d = pg >> TABLE_BITS;
          if (c.cmd == CMD_MAP) begin
            if (!dir_shadow[d][0]) begin
              dir_shadow[d] = {frame_next, 1'b0, DIR_FLAGS};
              frame_next++;
              for (int i = 0; i < TBL_DEPTH; i++) pte_shadow[d*TBL_DEPTH + i] = '0;
            end
            if (pte_shadow[pg][0]) begin
              r.status = ST_MAPPED;
              break;
            end
            pte_shadow[pg] = (c.phys_addr + 32'(r.pages_done) * 32'd4096)
                             | {20'd0, c.page_flags} | 32'd1;
          end else begin
            if (!dir_shadow[d][0] || !pte_shadow[pg][0]) begin
              r.status = ST_UNMAPPED;
              break;
            end
            pte_shadow[pg][0] = 1'b0;
          end
          r.pages_done++;
        end
      end
    end
    return r;
  endfunction

  always @(posedge clk) begin
    out_beat_t want;
    if (!rst_n) begin
      for (int i = 0; i < DIR_DEPTH; i++) dir_shadow[i] = '0;
      for (int i = 0; i < ALL_PAGES; i++) pte_shadow[i] = '0;
      frame_next = FRAME_RESET;
      expected_q.delete();
      fail_count <= 0;
      results_seen <= 0;
      pending <= 0;
    end else begin
      if (cfg_valid && cfg_ready) frame_next = cfg_data;
      if (in_valid && !in_stall) expected_q.push_back(walk_tables(in_data));
      if (out_valid && !out_stall) begin
        results_seen <= results_seen + 1;
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected result beat, actual %p", $time, out_data);
          fail_count <= fail_count + 1;
        end else begin
          want = expected_q.pop_front();
          if (want.status !== out_data.status || want.trans_addr !== out_data.trans_addr
              || want.pages_done !== out_data.pages_done) begin
            $display("%0t: mismatch, expected %p actual %p", $time, want, out_data);
            fail_count <= fail_count + 1;
          end
        end
      end
      pending <= expected_q.size();
    end
  end
endmodule

FILE: test/testbench.sv
// stimulus and verdict for the two-level page table manager
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import tlptm_pkg::*;

  // unused command code
  localparam logic [1:0] CMD_RSVD = 2'd3;

  logic clk, rst_n;
  logic in_valid, in_stall, out_valid, out_stall, cfg_valid, cfg_ready;
  in_beat_t  in_data;
  out_beat_t out_data;
  logic [FRAME_W-1:0] cfg_data;
  int fail_count, pending, results_seen;
  bit no_idle, hold_rx;
  int cmd_total;

  two_level_page_table_manager_top u_top (.*);
  page_table_checker u_chk (.*);

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  initial begin
    #400ms;
    $display("TEST FAILED");
    $finish;
  end

  // receiver: random stalls, plus one long hold-off
  initial begin
    out_stall = 0;
    forever begin
      @(negedge clk);
      if (hold_rx) begin
        out_stall <= 1;
        repeat (300) @(negedge clk);
        hold_rx = 0;
      end
      out_stall <= (!no_idle && $urandom_range(99) < 25);
    end
  end

  // valid stays up after a beat until the next one or a pause replaces it
  task automatic send(in_beat_t c);
    while (!no_idle && $urandom_range(99) < 25) begin
      in_valid <= 0;
      @(negedge clk);
    end
    in_valid <= 1;
    in_data  <= c;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
    cmd_total++;
  endtask

  task automatic drain();
    in_valid <= 0;
    while (pending != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_base(logic [FRAME_W-1:0] v);
    drain();
    cfg_valid <= 1;
    cfg_data  <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 0;
  endtask

  function automatic in_beat_t mk(logic [1:0] c, logic [23:0] va, logic [31:0] pa,
                                  logic [11:0] fl, logic [12:0] n);
    in_beat_t b;
    b = '{cmd: c, virt_addr: va, phys_addr: pa, page_flags: fl, page_count: n};
    return b;
  endfunction

  // mostly page aligned, in range, small counts
  function automatic in_beat_t rand_cmd();
    in_beat_t b;
    int r;
    r = $urandom_range(99);
    b.cmd        = (r < 5) ? CMD_RSVD : (r < 40 ? CMD_TRANSLATE : (r < 75 ? CMD_MAP : CMD_UNMAP));
    b.virt_addr  = {4'd0, 8'($urandom_range(20)), 12'd0} | 24'($urandom_range(15) << 16);
    b.phys_addr  = {20'($urandom), 12'd0};
    b.page_flags = 12'($urandom);
    b.page_count = 13'($urandom_range(6));
    if (b.cmd == CMD_TRANSLATE) b.virt_addr[11:0] = 12'($urandom);
    if ($urandom_range(99) < 8) b.virt_addr = 24'($urandom);
    if ($urandom_range(99) < 5) b.phys_addr = $urandom;
    if ($urandom_range(99) < 3) b.page_count = 13'($urandom_range(4096, 8191));
    return b;
  endfunction

  initial begin
    rst_n = 0; in_valid = 0; in_data = '0; cfg_valid = 0; cfg_data = '0;
    no_idle = 0; hold_rx = 0; cmd_total = 0;
    repeat (11) @(negedge clk);
    rst_n = 1;

    // directed: extremes and special cases
    send(mk(CMD_TRANSLATE, 24'hFFFFFF, '1, '1, '1));
    send(mk(CMD_TRANSLATE, 24'h000000, '0, '0, '0));
    send(mk(CMD_UNMAP, 24'h000000, '0, '0, 13'd1));
    send(mk(CMD_MAP, 24'h000000, 32'hFFFFF000, 12'hFFF, 13'd3));
    send(mk(CMD_TRANSLATE, 24'h001ABC, '0, '0, '0));
    send(mk(CMD_TRANSLATE, 24'h002FFF, '0, '0, '0));
    send(mk(CMD_MAP, 24'h001000, '0, '0, 13'd2));
    send(mk(CMD_MAP, 24'h000001, '0, '0, '0));
    send(mk(CMD_MAP, 24'h000000, 32'h00000800, '0, 13'd1));
    send(mk(CMD_UNMAP, 24'h000800, '0, '0, '0));
    send(mk(CMD_RSVD, 24'hFFFFFF, '1, '1, '1));
    send(mk(CMD_MAP, 24'hFFE000, 32'h12345000, 12'h555, 13'd4));
    send(mk(CMD_MAP, 24'h0FF000, 32'hAAAAA000, 12'hAAA, 13'd3));
    send(mk(CMD_TRANSLATE, 24'h100123, '0, '0, '0));
    send(mk(CMD_UNMAP, 24'h0FE000, '0, '0, 13'd4096));
    send(mk(CMD_UNMAP, 24'h000000, '0, '0, 13'd8191));
    send(mk(CMD_MAP, 24'h000000, '0, 12'h001, '0));
    send(mk(CMD_UNMAP, 24'h000000, '0, '0, '0));
    write_base('1);
    send(mk(CMD_MAP, 24'h200000, 32'h1000, '0, 13'd1));
    send(mk(CMD_MAP, 24'h300000, 32'h2000, '0, 13'd1));
    send(mk(CMD_TRANSLATE, 24'h300FFF, '0, '0, '0));
    write_base('0);

    for (int i = 0; i < 830; i++) begin
      no_idle = (i >= 200 && i < 300);
      if (i == 400) hold_rx = 1;
      if (i == 500) drain();
      if (i == 600) write_base(20'h80000);
      if (i == 700) write_base(20'($urandom));
      send(rand_cmd());
    end
    no_idle = 0;
    drain();
    repeat (20) @(negedge clk);
    $display("%0d commands sent, %0d result beats checked, base register written 4 times",
             cmd_total, results_seen);
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule

FILE: filelist.f
design/tlptm_pkg.sv
design/tlptm_dp.sv
design/tlptm_ctrl.sv
design/two_level_page_table_manager_top.sv
test/page_table_checker.sv
test/testbench.sv
